// ===== hw/rtl/button_gesture_detector_assert.svh =====
// Assertion macros for the button gesture detector.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef BUTTON_GESTURE_DETECTOR_ASSERT_SVH
`define BUTTON_GESTURE_DETECTOR_ASSERT_SVH

`ifndef SYNTH

// Checked property, disabled while reset is asserted
`define BGD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("button_gesture_detector: check failed");

// Checked property, evaluated during reset as well
`define BGD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("button_gesture_detector: check failed");

`else

`define BGD_ASSERT(lbl, clk, rstn, prop)
`define BGD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== hw/rtl/bgd_pkg.sv =====
// Package for the button gesture detector: event codes, register map, widths.
// No dependencies.
`timescale 1ns / 1ps

package bgd_pkg;

  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_REPEAT = 3'd4
  } event_e;

  // Register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LOW      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE_WINDOW = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS_TIME = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_WINDOW   = 3'd4;

  localparam logic [TIME_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [TIME_W-1:0] LONG_RST     = 16'd1000;
  localparam logic [TIME_W-1:0] REPEAT_RST   = 16'd200;
  localparam logic [TIME_W-1:0] DOUBLE_RST   = 16'd400;

endpackage

// ===== hw/rtl/button_gesture_detector.sv =====
// Top level of the button gesture detector: stream ports, APB register file,
// gesture state and result register. Depends on bgd_pkg and the assertion header.
`timescale 1ns / 1ps
// Takes one pin sample with its millisecond stamp per transaction and returns one
// event transaction for each: event code plus debounced down state. One sample
// is accepted every clock cycle; a result is presented once its sample has passed
// the input register and the single-pass gesture update has loaded the result
// register, and the pipeline stalls only when the result side holds off tready.
// Registers (APB, byte address 4*index): 0 active_low, 1 debounce_window,
// 2 long_press_time, 3 repeat_interval, 4 double_window; times in ms.
// Write registers only while no samples are in flight.

`include "button_gesture_detector_assert.svh"

module button_gesture_detector (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tdata: [0] pin_level, [32:1] now_ms, [39:33] zero
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [bgd_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // tdata: [2:0] event_code, [3] is_down, [7:4] zero
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [bgd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [bgd_pkg::APB_AW-1:0]       paddr,
  input  logic [bgd_pkg::APB_DW-1:0]       pwdata,
  output logic [bgd_pkg::APB_DW-1:0]       prdata,
  output logic                             pready
);

  localparam int unsigned SW = bgd_pkg::STAMP_W;
  localparam int unsigned TW = bgd_pkg::TIME_W;

  // ---------------- configuration registers ----------------
  logic          active_low_q;
  logic [TW-1:0] debounce_window_q;
  logic [TW-1:0] long_press_time_q;
  logic [TW-1:0] repeat_interval_q;
  logic [TW-1:0] double_window_q;
  logic [bgd_pkg::REG_IDX_W-1:0] reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bgd_pkg::APB_AW-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q      <= 1'b1;
      debounce_window_q <= bgd_pkg::DEBOUNCE_RST;
      long_press_time_q <= bgd_pkg::LONG_RST;
      repeat_interval_q <= bgd_pkg::REPEAT_RST;
      double_window_q   <= bgd_pkg::DOUBLE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        bgd_pkg::REG_ACTIVE_LOW:      active_low_q      <= pwdata[0];
        bgd_pkg::REG_DEBOUNCE_WINDOW: debounce_window_q <= pwdata[TW-1:0];
        bgd_pkg::REG_LONG_PRESS_TIME: long_press_time_q <= pwdata[TW-1:0];
        bgd_pkg::REG_REPEAT_INTERVAL: repeat_interval_q <= pwdata[TW-1:0];
        bgd_pkg::REG_DOUBLE_WINDOW:   double_window_q   <= pwdata[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bgd_pkg::REG_ACTIVE_LOW:      prdata = {{(bgd_pkg::APB_DW-1){1'b0}}, active_low_q};
      bgd_pkg::REG_DEBOUNCE_WINDOW: prdata = {{(bgd_pkg::APB_DW-TW){1'b0}}, debounce_window_q};
      bgd_pkg::REG_LONG_PRESS_TIME: prdata = {{(bgd_pkg::APB_DW-TW){1'b0}}, long_press_time_q};
      bgd_pkg::REG_REPEAT_INTERVAL: prdata = {{(bgd_pkg::APB_DW-TW){1'b0}}, repeat_interval_q};
      bgd_pkg::REG_DOUBLE_WINDOW:   prdata = {{(bgd_pkg::APB_DW-TW){1'b0}}, double_window_q};
      default:                      prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic          in_vld_q;
  logic          pin_q;
  logic [SW-1:0] now_q;
  logic          out_vld_q;
  logic          advance;

  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      pin_q <= s_axis_tdata[0];
      now_q <= s_axis_tdata[SW:1];
    end
  end

  // ---------------- gesture state ----------------
  logic          stable_down_q,     stable_down_d;
  logic          prev_raw_q,        prev_raw_d;
  logic [SW-1:0] debounce_start_q,  debounce_start_d;
  logic [SW-1:0] press_start_q,     press_start_d;
  logic [SW-1:0] release_stamp_q,   release_stamp_d;
  logic [SW-1:0] repeat_stamp_q,    repeat_stamp_d;
  logic          awaiting_second_q, awaiting_second_d;
  logic          long_done_q,       long_done_d;
  bgd_pkg::event_e ev_d;

  logic          level;
  logic          changed;
  logic          in_window;
  logic [SW-1:0] db_elapsed;
  logic [SW-1:0] press_elapsed;
  logic [SW-1:0] repeat_elapsed;
  logic [SW-1:0] release_elapsed;
  logic          long_hit;
  logic          repeat_hit;
  logic          double_ok;

  always_comb begin
    level           = active_low_q ? ~pin_q : pin_q;
    changed         = level != prev_raw_q;
    db_elapsed      = now_q - debounce_start_q;
    press_elapsed   = now_q - press_start_q;
    repeat_elapsed  = now_q - repeat_stamp_q;
    release_elapsed = now_q - release_stamp_q;
    // a level change restarts the window at this stamp, so elapsed is zero
    in_window  = changed ? (debounce_window_q != '0)
                         : (db_elapsed < {{(SW-TW){1'b0}}, debounce_window_q});
    long_hit   = press_elapsed  >= {{(SW-TW){1'b0}}, long_press_time_q};
    repeat_hit = repeat_elapsed >= {{(SW-TW){1'b0}}, repeat_interval_q};
    double_ok  = release_elapsed <= {{(SW-TW){1'b0}}, double_window_q};

    stable_down_d     = stable_down_q;
    prev_raw_d        = level;
    debounce_start_d  = changed ? now_q : debounce_start_q;
    press_start_d     = press_start_q;
    release_stamp_d   = release_stamp_q;
    repeat_stamp_d    = repeat_stamp_q;
    awaiting_second_d = awaiting_second_q;
    long_done_d       = long_done_q;
    ev_d              = bgd_pkg::EV_NONE;

    if (in_window) begin
      ev_d = bgd_pkg::EV_NONE;
    end else if (level && !stable_down_q) begin
      stable_down_d  = 1'b1;
      press_start_d  = now_q;
      repeat_stamp_d = now_q;
      long_done_d    = 1'b0;
    end else if (level) begin
      if (!long_done_q && long_hit) begin
        long_done_d    = 1'b1;
        repeat_stamp_d = now_q;
        ev_d           = bgd_pkg::EV_LONG;
      end else if (long_done_q && repeat_hit) begin
        repeat_stamp_d = now_q;
        ev_d           = bgd_pkg::EV_REPEAT;
      end
    end else if (stable_down_q) begin
      stable_down_d = 1'b0;
      if (long_done_q) begin
        awaiting_second_d = 1'b0;
      end else if (awaiting_second_q && double_ok) begin
        awaiting_second_d = 1'b0;
        ev_d              = bgd_pkg::EV_DOUBLE;
      end else begin
        awaiting_second_d = 1'b1;
        release_stamp_d   = now_q;
      end
    end else if (awaiting_second_q && !double_ok) begin
      // double-press wait ran out: report the earlier click as a single press
      awaiting_second_d = 1'b0;
      ev_d              = bgd_pkg::EV_PRESS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_down_q     <= 1'b0;
      prev_raw_q        <= 1'b0;
      debounce_start_q  <= '0;
      press_start_q     <= '0;
      release_stamp_q   <= '0;
      repeat_stamp_q    <= '0;
      awaiting_second_q <= 1'b0;
      long_done_q       <= 1'b0;
    end else if (advance) begin
      stable_down_q     <= stable_down_d;
      prev_raw_q        <= prev_raw_d;
      debounce_start_q  <= debounce_start_d;
      press_start_q     <= press_start_d;
      release_stamp_q   <= release_stamp_d;
      repeat_stamp_q    <= repeat_stamp_d;
      awaiting_second_q <= awaiting_second_d;
      long_done_q       <= long_done_d;
    end
  end

  // ---------------- result register ----------------
  bgd_pkg::event_e ev_q;
  logic            is_down_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ev_q      <= ev_d;
      is_down_q <= stable_down_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, is_down_q, ev_q};

  // ---------------- checks ----------------
  `BGD_ASSERT(a_held_events_while_down, clk_i, rst_ni,
    (out_vld_q && (ev_q == bgd_pkg::EV_LONG || ev_q == bgd_pkg::EV_REPEAT)) |-> is_down_q)
  `BGD_ASSERT(a_click_events_while_up, clk_i, rst_ni,
    (out_vld_q && (ev_q == bgd_pkg::EV_PRESS || ev_q == bgd_pkg::EV_DOUBLE)) |-> !is_down_q)
  `BGD_ASSERT(a_long_marks_state, clk_i, rst_ni,
    (advance && ev_d == bgd_pkg::EV_LONG) |=> (long_done_q && out_vld_q))
  `BGD_ASSERT(a_press_edge_silent, clk_i, rst_ni,
    (advance && !stable_down_q && stable_down_d) |-> (ev_d == bgd_pkg::EV_NONE))
  `BGD_ASSERT_ALWAYS(a_empty_stage_ready, clk_i,
    !in_vld_q |-> s_axis_tready)

endmodule
